// File: rtl/serial_rtc_pram_interface_macros.svh
// Assertion macros; they sample on i_clk and are disabled while i_rst_n is low.
`ifndef SERIAL_RTC_PRAM_INTERFACE_MACROS_SVH
`define SERIAL_RTC_PRAM_INTERFACE_MACROS_SVH

// Same-cycle implication.
`define SRTC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define SRTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/srtc_pkg.sv
package srtc_pkg;

    localparam int RAM_SIZE  = 20;
    localparam int SECS_CNT  = 2;

    // Codes carried in tuser
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [3:0] CNT_BYTE = 4'd8;

    localparam logic [7:0] PRAM_DEFAULT [RAM_SIZE] = '{
        8'd168, 8'd0, 8'd0, 8'd34, 8'd204, 8'd10, 8'd204, 8'd10, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd2, 8'd99, 8'd0, 8'd3, 8'd83, 8'd4, 8'd76
    };

endpackage

// File: rtl/serial_rtc_pram_interface.sv
// Channel | Dir | Signals                          | Contents
// s_axis  | in  | tvalid, tready, tdata, tuser     | tdata = port_byte, tuser = operation
// m_axis  | out | tvalid, tready, tdata            | tdata[0] = serial_bit, rest zero
//
// One transaction in gives exactly one transaction out.
// Each item is applied to the chip state in the cycle it is accepted; the result is
// registered, via skid if m_axis stalls. One item per clock while m_axis_tready is high.
// A two-deep output (result register plus skid register) keeps s_axis_tready high
// while one result waits; tready drops only when both are full.
// Reset (i_rst_n low, synchronous) clears the latches, counters and seconds,
// and reloads the parameter RAM with its default pattern.
`include "serial_rtc_pram_interface_macros.svh"

module serial_rtc_pram_interface (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] port_byte
    input  logic [1:0] s_axis_tuser,   // [1:0] operation
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] serial_bit, [7:1] zero
);
    import srtc_pkg::*;

    // Chip state
    logic        r_en_n, n_en_n;
    logic        r_clk_l, n_clk_l;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_cmd, n_cmd;
    logic [3:0]  r_bit_count, n_bit_count;
    logic        r_write_phase, n_write_phase;
    logic [31:0] r_secs [SECS_CNT];
    logic [31:0] n_secs [SECS_CNT];
    logic [7:0]  r_pram [RAM_SIZE];
    logic [7:0]  n_pram [RAM_SIZE];

    // Output stage
    logic r_out_valid, r_out_bit;
    logic r_skid_valid, r_skid_bit;

    logic       in_acc;
    logic       n_bit;
    logic [7:0] sb_in;
    logic [3:0] cnt_inc;
    logic [3:0] cnt_dec;
    logic [4:0] wr_addr;
    logic [4:0] rd_addr;
    logic [7:0] rd_data;
    logic [4:0] rd_lsb;

    assign s_axis_tready = !r_skid_valid;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_bit};

    // Register read decode for the command just formed
    assign sb_in   = {r_shift[6:0], s_axis_tdata[0]};
    assign rd_addr = sb_in[6:2];
    assign wr_addr = r_cmd[6:2];
    assign rd_lsb  = {~rd_addr[1:0], 3'b000};   // big-endian byte within counter

    always_comb begin
        rd_data = 8'd0;
        if (rd_addr[4]) begin
            rd_data = r_pram[{1'b0, rd_addr[3:0]}];
        end else if (!rd_addr[3]) begin
            rd_data = r_secs[rd_addr[2]][rd_lsb +: 8];
        end else if (!rd_addr[2]) begin
            rd_data = r_pram[5'(16 + int'(rd_addr[1:0]))];
        end
    end

    assign cnt_inc = r_bit_count + 4'd1;
    assign cnt_dec = r_bit_count - 4'd1;

    always_comb begin
        n_en_n        = r_en_n;
        n_clk_l       = r_clk_l;
        n_shift       = r_shift;
        n_cmd         = r_cmd;
        n_bit_count   = r_bit_count;
        n_write_phase = r_write_phase;
        n_secs        = r_secs;
        n_pram        = r_pram;
        n_bit         = 1'b0;
        unique case (s_axis_tuser)
            OP_WRITE: begin
                n_en_n  = s_axis_tdata[2];
                n_clk_l = s_axis_tdata[1];
                if (!s_axis_tdata[2] && s_axis_tdata[1]) begin
                    n_shift     = sb_in;
                    n_bit_count = cnt_inc;
                    if (cnt_inc == CNT_BYTE) begin
                        if (r_write_phase) begin
                            // data byte of a write command
                            if (wr_addr[4]) begin
                                n_pram[{1'b0, wr_addr[3:0]}] = sb_in;
                            end else if (!wr_addr[3]) begin
                                n_secs[wr_addr[2]][{~wr_addr[1:0], 3'b000} +: 8] = sb_in;
                            end else if (!wr_addr[2]) begin
                                n_pram[5'(16 + int'(wr_addr[1:0]))] = sb_in;
                            end
                            n_write_phase = 1'b0;
                            n_bit_count   = 4'd0;
                        end else begin
                            n_cmd = sb_in;
                            if (sb_in[7]) begin
                                n_shift = rd_data;   // count stays at eight for shifting out
                            end else begin
                                n_shift       = 8'd0;
                                n_write_phase = 1'b1;
                                n_bit_count   = 4'd0;
                            end
                        end
                    end
                end
            end
            OP_READ: begin
                if (!r_en_n && r_clk_l && (r_bit_count != 4'd0)) begin
                    n_bit_count = cnt_dec;
                    n_bit       = r_shift[cnt_dec[2:0]] & ~cnt_dec[3];
                end
            end
            OP_TICK: begin
                for (int i = 0; i < SECS_CNT; i++) begin
                    n_secs[i] = r_secs[i] + 32'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en_n        <= 1'b0;
            r_clk_l       <= 1'b0;
            r_shift       <= 8'd0;
            r_cmd         <= 8'd0;
            r_bit_count   <= 4'd0;
            r_write_phase <= 1'b0;
            for (int i = 0; i < SECS_CNT; i++) begin
                r_secs[i] <= 32'd0;
            end
            r_pram        <= PRAM_DEFAULT;
        end else if (in_acc) begin
            r_en_n        <= n_en_n;
            r_clk_l       <= n_clk_l;
            r_shift       <= n_shift;
            r_cmd         <= n_cmd;
            r_bit_count   <= n_bit_count;
            r_write_phase <= n_write_phase;
            r_secs        <= n_secs;
            r_pram        <= n_pram;
        end
    end

    // Result register with skid behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out_bit    <= r_skid_bit;
                r_skid_valid <= in_acc;
                r_skid_bit   <= n_bit;
            end else begin
                r_out_valid  <= in_acc;
                r_out_bit    <= n_bit;
            end
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
            r_skid_bit   <= n_bit;
        end
    end

    `SRTC_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid)
    `SRTC_ASSERT_NOW(a_write_phase_count, r_write_phase, !r_bit_count[3])
    `SRTC_ASSERT_NEXT(a_read_disabled_holds,
        in_acc && (s_axis_tuser == OP_READ) && r_en_n, $stable(r_bit_count))
    `SRTC_ASSERT_NEXT(a_tick_counts,
        in_acc && (s_axis_tuser == OP_TICK), r_secs[0] == $past(r_secs[0]) + 32'd1)

endmodule

// File: tb/serial_rtc_pram_interface_tb.sv
module serial_rtc_pram_interface_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srtc_pkg::*;

    // Run length and limits
    localparam int TOTAL_ITEMS  = 430;       // directed plus random; the last command runs over
    localparam int QUIET_FROM   = 400;       // no idling on either side from here on
    localparam int DRAIN_CYCLES = 8;         // result register plus skid, with margin
    localparam int CYCLE_LIMIT  = 200000;

    // Port byte layout and command layout
    localparam int PB_DATA  = 0;
    localparam int PB_CLK   = 1;
    localparam int PB_EN_N  = 2;
    localparam int CMD_DIR  = 7;             // set: read command
    localparam logic READ_FLAG  = 1'b1;
    localparam logic WRITE_FLAG = 1'b0;

    // Unused operation code: the block must ignore it
    localparam logic [1:0] OP_SPARE = 2'd3;

    // Address map boundaries
    localparam int SECS_END  = 8;            // 0..7 seconds bytes
    localparam int HIGH_END  = 12;           // 8..11 RAM bytes 16..19
    localparam int LOW_BASE  = 16;           // 16..31 RAM bytes 0..15
    localparam int HIGH_BASE = 16;           // RAM index of the first high byte

    // Shadow of the chip: tracks the latches, shifter and storage, and queues
    // the serial bit that each accepted transaction should return.
    class rtc_shadow;
        bit         en_n;
        bit         clk_hi;
        bit [7:0]   shreg;
        bit [7:0]   cmd;
        bit [3:0]   cnt;
        bit         wr_phase;
        bit [7:0]   secs [8];
        bit [7:0]   pram [RAM_SIZE];
        bit         serial_bits_due [$];
        int         errors;

        function new();
            en_n     = 1'b0;
            clk_hi   = 1'b0;
            shreg    = '0;
            cmd      = '0;
            cnt      = '0;
            wr_phase = 1'b0;
            errors   = 0;
            foreach (secs[i]) secs[i] = '0;
            foreach (pram[i]) pram[i] = PRAM_DEFAULT[i];
        endfunction

        function void apply_port_access(logic [1:0] op, logic [7:0] pb);
            bit       bit_out;
            bit [4:0] addr;
            int       b;
            int       k;
            bit_out = 1'b0;
            case (op)
                OP_WRITE: begin
                    en_n   = pb[PB_EN_N];
                    clk_hi = pb[PB_CLK];
                    if (!en_n && clk_hi) begin
                        shreg = {shreg[6:0], pb[PB_DATA]};
                        cnt   = cnt + 4'd1;
                        if (cnt == CNT_BYTE) begin
                            if (wr_phase) begin
                                // data byte of a write command
                                addr = cmd[6:2];
                                if (addr < SECS_END)
                                    secs[addr[2:0]] = shreg;
                                else if (addr < HIGH_END)
                                    pram[HIGH_BASE + addr[1:0]] = shreg;
                                else if (addr >= LOW_BASE)
                                    pram[addr[3:0]] = shreg;
                                wr_phase = 1'b0;
                                cnt      = '0;
                            end else begin
                                cmd   = shreg;
                                addr  = cmd[6:2];
                                shreg = '0;
                                if (cmd[CMD_DIR]) begin
                                    // 12..15 read back as zero
                                    if (addr < SECS_END)
                                        shreg = secs[addr[2:0]];
                                    else if (addr < HIGH_END)
                                        shreg = pram[HIGH_BASE + addr[1:0]];
                                    else if (addr >= LOW_BASE)
                                        shreg = pram[addr[3:0]];
                                end else begin
                                    wr_phase = 1'b1;
                                    cnt      = '0;
                                end
                            end
                        end
                    end
                end
                OP_READ: begin
                    if (!en_n && clk_hi && cnt != 0) begin
                        cnt     = cnt - 4'd1;
                        bit_out = (cnt > 4'd7) ? 1'b0 : shreg[cnt[2:0]];
                    end
                end
                OP_TICK: begin
                    // two big-endian counters, each wrapping at 2^32
                    for (b = 0; b < 8; b += 4) begin
                        for (k = 3; k >= 0; k--) begin
                            secs[b + k] = secs[b + k] + 8'd1;
                            if (secs[b + k] != 0) break;
                        end
                    end
                end
                default: ;
            endcase
            serial_bits_due.push_back(bit_out);
        endfunction

        function void check_serial_bit(logic [7:0] got);
            logic [7:0] want;
            if (serial_bits_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = {7'd0, serial_bits_due.pop_front()};
            if (got !== want) begin
                $display("%0t: serial bit mismatch, expected %h, actual %h",
                         $time, want, got);
                errors++;
            end
        endfunction

        function int pending();
            return serial_bits_due.size();
        endfunction
    endclass

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = '0;     // [7:0] port_byte
    logic [1:0] s_axis_tuser  = OP_WRITE; // [1:0] operation
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b1;
    logic [7:0] m_axis_tdata;           // [0] serial_bit, [7:1] zero

    rtc_shadow shadow;
    int        items_sent  = 0;
    int        gap_rate    = 0;          // 0: no sender gaps in this stretch
    int        stall_rate  = 0;          // 0: no receiver stalls in this stretch
    int        sink_cycles = 0;
    int        cycle_count = 0;
    bit        quiet       = 1'b0;

    serial_rtc_pram_interface uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, shadow.pending());
            $display("status: fail");
            $finish;
        end
    end

    // Result monitor: values read here are the pre-edge ones the block saw
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            shadow.check_serial_bit(m_axis_tdata);
    end

    // Receiver back-pressure: short stall bursts, density re-picked from a sink_cycles count
    initial begin
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            sink_cycles++;
            if (sink_cycles % 32 == 0)
                stall_rate = $urandom_range(0, 2) * 3;
            if (!quiet && stall_rate != 0 && $urandom_range(0, stall_rate) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // One input transaction; returns once it has been accepted.
    // tvalid is left high so back-to-back transactions need no extra edge.
    task automatic send_item(input logic [1:0] op, input logic [7:0] pb);
        if (!quiet && gap_rate != 0 && $urandom_range(0, gap_rate) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= pb;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        shadow.apply_port_access(op, pb);
        items_sent++;
        if (items_sent % 40 == 0)
            gap_rate = $urandom_range(0, 2) * 4;
        if (items_sent >= QUIET_FROM)
            quiet = 1'b1;
    endtask

    // Port write with random don't-care bits above the three port lines
    task automatic port_write(input bit en_n, input bit clk, input bit d);
        logic [7:0] pb;
        pb = 8'($urandom);
        pb[PB_EN_N] = en_n;
        pb[PB_CLK]  = clk;
        pb[PB_DATA] = d;
        send_item(OP_WRITE, pb);
    endtask

    // Shift a byte MSB first; loose mode scatters non-shifting writes between bits
    task automatic shift_byte_in(input logic [7:0] v, input bit loose);
        for (int i = 7; i >= 0; i--) begin
            if (loose && $urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 1))
                    port_write(1'($urandom_range(0, 1)), 1'b0, 1'($urandom_range(0, 1)));
                else
                    port_write(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            port_write(1'b0, 1'b1, v[i]);
        end
    endtask

    // Bring the chip back to command phase with no bits pending.
    // Shifts finish any partial byte; reads drain a loaded byte.
    task automatic realign();
        while (shadow.cnt != 0 || shadow.wr_phase) begin
            if (shadow.en_n || !shadow.clk_hi || shadow.wr_phase || shadow.cnt < CNT_BYTE)
                port_write(1'b0, 1'b1, 1'($urandom_range(0, 1)));
            else
                send_item(OP_READ, 8'($urandom));
        end
    endtask

    task automatic write_register(input logic [4:0] addr, input logic [7:0] value);
        logic [1:0] pad;
        pad = 2'($urandom);
        realign();
        shift_byte_in({WRITE_FLAG, addr, pad}, 1'b1);
        shift_byte_in(value, 1'b1);
    endtask

    // Read command then eight bit reads and one more, which finds nothing left; loose mode may skip that one
    task automatic read_register(input logic [4:0] addr, input bit loose);
        logic [1:0] pad;
        int         n;
        pad = loose ? 2'($urandom) : 2'd0;
        n   = CNT_BYTE + (loose ? $urandom_range(0, 1) : 1);
        realign();
        shift_byte_in({READ_FLAG, addr, pad}, loose);
        for (int i = 0; i < n; i++) begin
            if (loose && $urandom_range(0, 9) == 0)
                send_item(OP_TICK, 8'($urandom));
            send_item(OP_READ, 8'($urandom));
        end
    endtask

    // Hold the sender off until every outstanding result has come back
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (shadow.pending() != 0);
    endtask

    initial begin
        logic [2:0] base;
        shadow = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: read with nothing loaded, the unused code, ticks,
        // all-ones and all-zeros port bytes (neither shifts)
        send_item(OP_READ, 8'hFF);
        send_item(OP_SPARE, 8'h00);
        send_item(OP_TICK, 8'h00);
        send_item(OP_TICK, 8'hFF);
        send_item(OP_WRITE, 8'hFF);
        send_item(OP_WRITE, 8'h00);
        // seconds byte 3 now holds 2; read it back plus one empty read
        read_register(5'd3, 1'b0);
        wait_for_drain();

        // Random: mostly well-formed commands with random content, plus noise
        while (items_sent < TOTAL_ITEMS) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6:
                    read_register(5'($urandom), 1'b1);
                7, 8, 9, 10, 11:
                    write_register(5'($urandom),
                                   ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom));
                12, 13:
                    repeat ($urandom_range(1, 4)) send_item(OP_TICK, 8'($urandom));
                14: begin
                    // preset a counter near its wrap point, tick, then read it back
                    base = 3'($urandom_range(0, 1) * 4);
                    for (int k = 0; k < 3; k++)
                        write_register(5'(base + k), 8'hFF);
                    write_register(5'(base + 3), 8'hFE + 8'($urandom_range(0, 1)));
                    repeat ($urandom_range(1, 3)) send_item(OP_TICK, 8'($urandom));
                    read_register(5'(base + $urandom_range(0, 3)), 1'b1);
                end
                15, 16:
                    repeat ($urandom_range(1, 6))
                        send_item(2'($urandom_range(0, 3)), 8'($urandom));
                17: begin
                    // broken command: partial byte then arbitrary transactions
                    realign();
                    repeat ($urandom_range(1, 7))
                        port_write(1'b0, 1'b1, 1'($urandom_range(0, 1)));
                    repeat ($urandom_range(1, 4))
                        send_item(2'($urandom_range(0, 3)), 8'($urandom));
                end
                18:
                    wait_for_drain();
                default:
                    shift_byte_in(8'($urandom), 1'b1);
            endcase
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (shadow.errors == 0 && shadow.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
